// File: rtl/core/fcou_pkg.sv
// ----------------------------------------------------------------------------
// fcou_pkg
// Shared types and constants for the four-channel oversampled 8N1 UART.
// ----------------------------------------------------------------------------
package fcou_pkg;

  // payload widths fixed by the item format
  localparam int MODE_W = 2;
  localparam int CH_W   = 2;
  localparam int DATA_W = 8;
  localparam int LINE_W = 4;

  // bit counter within a frame: start is bit 0, data 1..8, stop 9
  localparam int             BIT_W     = 4;
  localparam logic [BIT_W-1:0] STOP_BIT  = 4'd9;
  localparam logic [BIT_W-1:0] FRAME_END = 4'd10;

  // item kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_QUEUE = 2'd1,
    MODE_TAKE  = 2'd2
  } mode_t;

  // per-lane status handed to the merging stage
  typedef struct packed {
    logic              level;    // tx line after this item
    logic              avail;    // rx ring nonempty after this item
    logic              wr_ok;    // tx ring has room before this item
    logic              rd_ok;    // rx ring nonempty before this item
    logic [DATA_W-1:0] rd_data;  // byte at the rx ring read pointer
  } lane_status_t;

endpackage

// File: rtl/core/four_channel_oversampled_uart.sv
// ----------------------------------------------------------------------------
// four_channel_oversampled_uart
// Four 8N1 UART channels on an oversampled bit tick, with per-channel
// transmit and receive rings, one lane per channel.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one item per handshake: a
//   bit tick with the sampled receive lines, a byte to queue for a channel's
//   transmitter, or a request to take a channel's oldest received byte.
//   The result channel (out_valid/out_ready) returns exactly one item per
//   input item: transmit line levels, the taken byte and its valid flag,
//   the queue acceptance flag and the receive-available mask.
//   The result is in the output register the cycle after the item is
//   accepted. One item is accepted every cycle while the output register is
//   free to load; the per-channel counters and ring pointers all update
//   together and each ring has one write and one registered read per cycle.
//   Reset clears all counters and pointers, idles the receivers and drives
//   every transmit line high; ring contents are not cleared and no clearing
//   pass runs, so items are taken right after reset.
//   When the receiver stalls, the result holds in the output register and
//   in_ready drops until it is taken.
// ----------------------------------------------------------------------------
module four_channel_oversampled_uart #(
  parameter int TICKS_PER_BIT = 4,
  parameter int RX_DEPTH      = 16,
  parameter int TX_DEPTH      = 16,
  parameter int CHANNELS      = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fcou_pkg::MODE_W-1:0]  in_mode,
  input  logic [fcou_pkg::CH_W-1:0]    in_channel,
  input  logic [fcou_pkg::DATA_W-1:0]  in_data_in,
  input  logic [fcou_pkg::LINE_W-1:0]  in_rx_lines,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fcou_pkg::LINE_W-1:0]  out_tx_lines,
  output logic [fcou_pkg::DATA_W-1:0]  out_read_data,
  output logic                         out_read_valid,
  output logic                         out_write_accepted,
  output logic [fcou_pkg::LINE_W-1:0]  out_rx_available
);
  import fcou_pkg::*;

  logic                fire;
  logic                tick;
  logic [CHANNELS-1:0] lane_line;
  logic [CHANNELS-1:0] lane_wr;
  logic [CHANNELS-1:0] lane_rd;
  lane_status_t        lane_st [CHANNELS];

  // item decode
  assign fire = in_valid && in_ready;
  assign tick = fire && (in_mode == MODE_TICK);

  // one lane per channel
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    if (c < LINE_W) begin : g_line
      assign lane_line[c] = in_rx_lines[c];
    end else begin : g_idle
      assign lane_line[c] = 1'b1;
    end
    assign lane_wr[c] = fire && (in_mode == MODE_QUEUE) && (int'(in_channel) == c);
    assign lane_rd[c] = fire && (in_mode == MODE_TAKE) && (int'(in_channel) == c);

    fcou_lane #(
      .TICKS_PER_BIT (TICKS_PER_BIT),
      .RX_DEPTH      (RX_DEPTH),
      .TX_DEPTH      (TX_DEPTH)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .tick    (tick),
      .line    (lane_line[c]),
      .wr_en   (lane_wr[c]),
      .wr_data (in_data_in),
      .rd_en   (lane_rd[c]),
      .status  (lane_st[c])
    );
  end

  // merge lanes into the result item
  fcou_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk                (clk),
    .rst_n              (rst_n),
    .fire               (fire),
    .mode               (in_mode),
    .channel            (in_channel),
    .lane_st            (lane_st),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tx_lines       (out_tx_lines),
    .out_read_data      (out_read_data),
    .out_read_valid     (out_read_valid),
    .out_write_accepted (out_write_accepted),
    .out_rx_available   (out_rx_available)
  );

  // an accepted item always yields a result next cycle
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("accepted item produced no result");

  // a result cannot both take and queue a byte
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_read_valid && out_write_accepted))
    else $error("result reports both a take and a queue");

  // an empty take reports a zero byte
  a_empty_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_read_valid) |-> (out_read_data == '0))
    else $error("read data nonzero without a taken byte");

endmodule

// File: rtl/core/fcou_lane.sv
// ----------------------------------------------------------------------------
// fcou_lane
// One UART channel: oversampling receiver, transmitter, and the receive and
// transmit rings, each with a registered read port that tracks its tail.
// ----------------------------------------------------------------------------
module fcou_lane #(
  parameter int TICKS_PER_BIT = 4,
  parameter int RX_DEPTH      = 16,
  parameter int TX_DEPTH      = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tick,
  input  logic                         line,
  input  logic                         wr_en,
  input  logic [fcou_pkg::DATA_W-1:0]  wr_data,
  input  logic                         rd_en,
  output fcou_pkg::lane_status_t       status
);
  import fcou_pkg::*;

  localparam int SUB_W = $clog2(TICKS_PER_BIT);
  localparam int RX_PW = $clog2(RX_DEPTH);
  localparam int TX_PW = $clog2(TX_DEPTH);
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_BIT - 1);
  localparam logic [SUB_W-1:0] SUB_MID  = SUB_W'(TICKS_PER_BIT / 2);
  localparam logic [SUB_W-1:0] SUB_ONE  = SUB_W'(1);

  // receiver state
  logic              rx_busy_r, rx_busy_nxt;
  logic [BIT_W-1:0]  rx_bit_r, rx_bit_nxt;
  logic [SUB_W-1:0]  rx_sub_r, rx_sub_nxt;
  logic [DATA_W-1:0] rx_shift_r, rx_shift_nxt;
  logic [RX_PW-1:0]  rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [RX_PW-1:0]  rx_head_inc, rx_tail_inc, rx_rd_addr;
  logic [BIT_W-1:0]  rx_bit_adv;
  logic [SUB_W-1:0]  rx_sub_adv;
  logic              rx_we;
  logic [DATA_W-1:0] rx_mem [RX_DEPTH];
  logic [DATA_W-1:0] rx_rd_r;

  // transmitter state
  logic              tx_busy_r, tx_busy_nxt;
  logic [BIT_W-1:0]  tx_bit_r, tx_bit_nxt;
  logic [SUB_W-1:0]  tx_sub_r, tx_sub_nxt;
  logic [DATA_W-1:0] tx_shift_r, tx_shift_nxt;
  logic              tx_level_r, tx_level_nxt;
  logic [TX_PW-1:0]  tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [TX_PW-1:0]  tx_head_inc, tx_tail_inc, tx_rd_addr;
  logic [BIT_W-1:0]  tx_bit_adv;
  logic [SUB_W-1:0]  tx_sub_adv;
  logic              tx_we;
  logic [DATA_W-1:0] tx_mem [TX_DEPTH];
  logic [DATA_W-1:0] tx_rd_r;

  // ring pointer increments with wrap at depth
  assign rx_head_inc = (rx_head_r == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_head_r + RX_PW'(1);
  assign rx_tail_inc = (rx_tail_r == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_tail_r + RX_PW'(1);
  assign tx_head_inc = (tx_head_r == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_head_r + TX_PW'(1);
  assign tx_tail_inc = (tx_tail_r == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_tail_r + TX_PW'(1);

  // tick position advance, sub-bit counter wraps into the bit counter
  assign rx_sub_adv = (rx_sub_r == SUB_LAST) ? '0 : rx_sub_r + SUB_ONE;
  assign rx_bit_adv = (rx_sub_r == SUB_LAST) ? rx_bit_r + BIT_W'(1) : rx_bit_r;
  assign tx_sub_adv = (tx_sub_r == SUB_LAST) ? '0 : tx_sub_r + SUB_ONE;
  assign tx_bit_adv = (tx_sub_r == SUB_LAST) ? tx_bit_r + BIT_W'(1) : tx_bit_r;

  // receiver next state
  always_comb begin
    rx_busy_nxt  = rx_busy_r;
    rx_bit_nxt   = rx_bit_r;
    rx_sub_nxt   = rx_sub_r;
    rx_shift_nxt = rx_shift_r;
    rx_head_nxt  = rx_head_r;
    rx_tail_nxt  = rx_tail_r;
    rx_we        = 1'b0;
    if (tick) begin
      if (!rx_busy_r) begin
        // falling edge at idle starts a frame
        if (!line) begin
          rx_busy_nxt  = 1'b1;
          rx_bit_nxt   = '0;
          rx_sub_nxt   = SUB_ONE;
          rx_shift_nxt = '0;
        end
      end else begin
        rx_bit_nxt = rx_bit_adv;
        rx_sub_nxt = rx_sub_adv;
        if (rx_sub_adv == SUB_MID && rx_bit_adv != '0 && rx_bit_adv < STOP_BIT) begin
          rx_shift_nxt = {line, rx_shift_r[DATA_W-1:1]};
        end else if (rx_sub_adv == SUB_MID && rx_bit_adv >= STOP_BIT && !line) begin
          // framing error, drop the frame
          rx_busy_nxt = 1'b0;
        end
        if (rx_bit_adv == FRAME_END) begin
          rx_busy_nxt = 1'b0;
          if (rx_head_inc != rx_tail_r) begin
            rx_we       = 1'b1;
            rx_head_nxt = rx_head_inc;
          end
        end
      end
    end
    // take a received byte
    if (rd_en && (rx_head_r != rx_tail_r)) begin
      rx_tail_nxt = rx_tail_inc;
    end
  end

  // transmitter next state
  always_comb begin
    tx_busy_nxt  = tx_busy_r;
    tx_bit_nxt   = tx_bit_r;
    tx_sub_nxt   = tx_sub_r;
    tx_shift_nxt = tx_shift_r;
    tx_level_nxt = tx_level_r;
    tx_head_nxt  = tx_head_r;
    tx_tail_nxt  = tx_tail_r;
    tx_we        = 1'b0;
    if (tick) begin
      if (!tx_busy_r) begin
        // pop the ring and drive the start bit
        if (tx_head_r != tx_tail_r) begin
          tx_busy_nxt  = 1'b1;
          tx_bit_nxt   = '0;
          tx_sub_nxt   = '0;
          tx_shift_nxt = tx_rd_r;
          tx_level_nxt = 1'b0;
          tx_tail_nxt  = tx_tail_inc;
        end
      end else begin
        tx_bit_nxt = tx_bit_adv;
        tx_sub_nxt = tx_sub_adv;
        if (tx_sub_adv == '0) begin
          if (tx_bit_adv == FRAME_END) begin
            tx_busy_nxt  = 1'b0;
            tx_level_nxt = 1'b1;
          end else if (tx_bit_adv == STOP_BIT) begin
            tx_level_nxt = 1'b1;
          end else begin
            tx_level_nxt = tx_shift_r[0];
            tx_shift_nxt = {1'b0, tx_shift_r[DATA_W-1:1]};
          end
        end
      end
    end
    // queue a transmit byte
    if (wr_en && (tx_head_inc != tx_tail_r)) begin
      tx_we       = 1'b1;
      tx_head_nxt = tx_head_inc;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_busy_r  <= 1'b0;
      rx_bit_r   <= '0;
      rx_sub_r   <= '0;
      rx_head_r  <= '0;
      rx_tail_r  <= '0;
      tx_busy_r  <= 1'b0;
      tx_bit_r   <= '0;
      tx_sub_r   <= '0;
      tx_level_r <= 1'b1;
      tx_head_r  <= '0;
      tx_tail_r  <= '0;
    end else begin
      rx_busy_r  <= rx_busy_nxt;
      rx_bit_r   <= rx_bit_nxt;
      rx_sub_r   <= rx_sub_nxt;
      rx_head_r  <= rx_head_nxt;
      rx_tail_r  <= rx_tail_nxt;
      tx_busy_r  <= tx_busy_nxt;
      tx_bit_r   <= tx_bit_nxt;
      tx_sub_r   <= tx_sub_nxt;
      tx_level_r <= tx_level_nxt;
      tx_head_r  <= tx_head_nxt;
      tx_tail_r  <= tx_tail_nxt;
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    rx_shift_r <= rx_shift_nxt;
    tx_shift_r <= tx_shift_nxt;
  end

  // read ports follow the next tail, with bypass of a same-cycle write
  assign rx_rd_addr = rst_n ? rx_tail_nxt : '0;
  assign tx_rd_addr = rst_n ? tx_tail_nxt : '0;

  // receive ring
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_head_r] <= rx_shift_r;
    end
    if (rx_we && rx_head_r == rx_rd_addr) begin
      rx_rd_r <= rx_shift_r;
    end else begin
      rx_rd_r <= rx_mem[rx_rd_addr];
    end
  end

  // transmit ring
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_head_r] <= wr_data;
    end
    if (tx_we && tx_head_r == tx_rd_addr) begin
      tx_rd_r <= wr_data;
    end else begin
      tx_rd_r <= tx_mem[tx_rd_addr];
    end
  end

  // status toward the merging stage
  assign status.level   = tx_level_nxt;
  assign status.avail   = (rx_head_nxt != rx_tail_nxt);
  assign status.wr_ok   = (tx_head_inc != tx_tail_r);
  assign status.rd_ok   = (rx_head_r != rx_tail_r);
  assign status.rd_data = rx_rd_r;

endmodule

// File: rtl/core/fcou_merge.sv
// ----------------------------------------------------------------------------
// fcou_merge
// Combines the lane status into one result item and holds it in the output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
module fcou_merge #(
  parameter int CHANNELS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [fcou_pkg::MODE_W-1:0]  mode,
  input  logic [fcou_pkg::CH_W-1:0]    channel,
  input  fcou_pkg::lane_status_t       lane_st [CHANNELS],
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fcou_pkg::LINE_W-1:0]  out_tx_lines,
  output logic [fcou_pkg::DATA_W-1:0]  out_read_data,
  output logic                         out_read_valid,
  output logic                         out_write_accepted,
  output logic [fcou_pkg::LINE_W-1:0]  out_rx_available
);
  import fcou_pkg::*;

  logic              out_valid_r;
  logic [LINE_W-1:0] tx_lines_r, tx_lines_nxt;
  logic [LINE_W-1:0] avail_r, avail_nxt;
  logic [DATA_W-1:0] rd_data_r, rd_data_nxt;
  logic              rd_valid_r, rd_valid_nxt;
  logic              wr_acc_r, wr_acc_nxt;
  logic              sel_rd_ok, sel_wr_ok;
  logic [DATA_W-1:0] sel_rd_data;

  // pick the addressed lane and gather line levels and receive-available flags
  always_comb begin
    sel_rd_ok    = 1'b0;
    sel_wr_ok    = 1'b0;
    sel_rd_data  = '0;
    tx_lines_nxt = '0;
    avail_nxt    = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (int'(channel) == c) begin
        sel_rd_ok   = lane_st[c].rd_ok;
        sel_wr_ok   = lane_st[c].wr_ok;
        sel_rd_data = lane_st[c].rd_data;
      end
      if (c < LINE_W) begin
        tx_lines_nxt[c] = lane_st[c].level;
        avail_nxt[c]    = lane_st[c].avail;
      end
    end
    rd_valid_nxt = (mode == MODE_TAKE) && sel_rd_ok;
    wr_acc_nxt   = (mode == MODE_QUEUE) && sel_wr_ok;
    rd_data_nxt  = rd_valid_nxt ? sel_rd_data : '0;
  end

  // output register, free to load when empty or being taken
  assign in_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tx_lines_r <= tx_lines_nxt;
      avail_r    <= avail_nxt;
      rd_data_r  <= rd_data_nxt;
      rd_valid_r <= rd_valid_nxt;
      wr_acc_r   <= wr_acc_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tx_lines       = tx_lines_r;
  assign out_read_data      = rd_data_r;
  assign out_read_valid     = rd_valid_r;
  assign out_write_accepted = wr_acc_r;
  assign out_rx_available   = avail_r;

endmodule

// File: test/four_channel_oversampled_uart_tb.sv
// ----------------------------------------------------------------------------
// four_channel_oversampled_uart_tb
// Self-checking bench for the four-channel 8N1 UART: a short directed table,
// then traffic phases with framed serial input on all receive lines, checked
// item by item against a cycle-free model of the channels.
// ----------------------------------------------------------------------------
module four_channel_oversampled_uart_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcou_pkg::*;

  localparam int TICKS_PER_BIT = 4;
  localparam int RX_DEPTH      = 16;
  localparam int TX_DEPTH      = 16;
  localparam int CHANNELS      = 4;

  // frame timing in ticks
  localparam int RX_DATA_END = TICKS_PER_BIT * 9;
  localparam int RX_FRAME    = TICKS_PER_BIT * 10;
  localparam int TX_STOP     = TICKS_PER_BIT * 9 + 2;
  localparam int TX_FRAME    = TICKS_PER_BIT * 10 + 2;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int LATENCY      = 1;
  localparam int ITEM_TARGET  = 1650;
  localparam int HOLD_AT      = 1100;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 400000;

  // traffic phase kinds
  localparam int PH_QUIET = 0;
  localparam int PH_FLOOD = 1;
  localparam int PH_DRAIN = 2;
  localparam int PH_MIXED = 3;

  // receiver stall styles
  localparam int RDY_ALWAYS   = 0;
  localparam int RDY_MOSTLY   = 1;
  localparam int RDY_PERIODIC = 2;
  localparam int RDY_SPARSE   = 3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CH_W-1:0]   chan;
    logic [DATA_W-1:0] data;
    logic [LINE_W-1:0] rx;
  } uart_item_t;

  typedef struct packed {
    logic [LINE_W-1:0] tx_lines;
    logic [DATA_W-1:0] rd_data;
    logic              rd_valid;
    logic              wr_ok;
    logic [LINE_W-1:0] rx_avail;
  } uart_result_t;

  typedef struct packed {
    uart_item_t   item;
    logic         typed;
    uart_result_t want;
  } uart_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MODE_W-1:0] in_mode = '0;
  logic [CH_W-1:0] in_channel = '0;
  logic [DATA_W-1:0] in_data_in = '0;
  logic [LINE_W-1:0] in_rx_lines = '1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LINE_W-1:0] out_tx_lines;
  logic [DATA_W-1:0] out_read_data;
  logic out_read_valid;
  logic out_write_accepted;
  logic [LINE_W-1:0] out_rx_available;

  // typed expectation riding along with the offered item
  logic row_typed = 1'b0;
  uart_result_t row_expect = '0;

  four_channel_oversampled_uart #(
    .TICKS_PER_BIT(TICKS_PER_BIT),
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH),
    .CHANNELS(CHANNELS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_channel(in_channel),
    .in_data_in(in_data_in),
    .in_rx_lines(in_rx_lines),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_tx_lines(out_tx_lines),
    .out_read_data(out_read_data),
    .out_read_valid(out_read_valid),
    .out_write_accepted(out_write_accepted),
    .out_rx_available(out_rx_available)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // channel state mirrored by the predictor
  int         rx_phase_m [CHANNELS];
  logic [7:0] rx_shift_m [CHANNELS];
  logic [7:0] rx_ring_m  [CHANNELS][RX_DEPTH];
  int         rx_wr      [CHANNELS];
  int         rx_rd      [CHANNELS];
  int         tx_phase_m [CHANNELS];
  logic [7:0] tx_shift_m [CHANNELS];
  logic [7:0] tx_ring_m  [CHANNELS][TX_DEPTH];
  int         tx_wr      [CHANNELS];
  int         tx_rd      [CHANNELS];
  logic       tx_level_m [CHANNELS];

  uart_result_t uart_expect_q[$];
  uart_row_t    stim_rows[$];
  int           errors = 0;

  // receiver of one channel on one tick
  function automatic void rx_lane_tick(int c, logic line);
    int ph;
    ph = rx_phase_m[c];
    if (ph == 0) begin
      if (!line) begin
        rx_phase_m[c] = 1;
        rx_shift_m[c] = '0;
      end
      return;
    end
    ph++;
    // mid-bit sample: data bits shift in, the stop bit must be high
    if (((ph % TICKS_PER_BIT) == (TICKS_PER_BIT / 2)) && (ph > TICKS_PER_BIT)) begin
      if (ph < RX_DATA_END) begin
        rx_shift_m[c] = {line, rx_shift_m[c][7:1]};
      end else if (!line) begin
        rx_phase_m[c] = 0;
        return;
      end
    end
    // frame done: store unless the ring is full
    if (ph >= RX_FRAME) begin
      if (((rx_wr[c] + 1) % RX_DEPTH) != rx_rd[c]) begin
        rx_ring_m[c][rx_wr[c]] = rx_shift_m[c];
        rx_wr[c] = (rx_wr[c] + 1) % RX_DEPTH;
      end
      ph = 0;
    end
    rx_phase_m[c] = ph;
  endfunction

  // transmitter of one channel on one tick
  function automatic void tx_lane_tick(int c);
    int ph;
    ph = tx_phase_m[c];
    if (ph == 0) begin
      if (tx_rd[c] == tx_wr[c]) return;
      ph = 1;
    end
    ph++;
    if (ph == 2) begin
      tx_shift_m[c] = tx_ring_m[c][tx_rd[c]];
      tx_rd[c] = (tx_rd[c] + 1) % TX_DEPTH;
      tx_level_m[c] = 1'b0;
    end else if ((ph % TICKS_PER_BIT) == 2) begin
      if (ph == TX_STOP) begin
        tx_level_m[c] = 1'b1;
      end else begin
        tx_level_m[c] = tx_shift_m[c][0];
        tx_shift_m[c] = tx_shift_m[c] >> 1;
      end
    end
    if (ph >= TX_FRAME) begin
      ph = 0;
      tx_level_m[c] = 1'b1;
    end
    tx_phase_m[c] = ph;
  endfunction

  // one item through the channel model
  function automatic uart_result_t uart_predict(uart_item_t it);
    uart_result_t r;
    int c;
    int ch;
    r = '0;
    ch = int'(it.chan);
    if (it.mode == MODE_TICK) begin
      for (c = 0; c < CHANNELS; c++) begin
        rx_lane_tick(c, it.rx[c]);
        tx_lane_tick(c);
      end
    end else if (it.mode == MODE_QUEUE) begin
      if (((tx_wr[ch] + 1) % TX_DEPTH) != tx_rd[ch]) begin
        tx_ring_m[ch][tx_wr[ch]] = it.data;
        tx_wr[ch] = (tx_wr[ch] + 1) % TX_DEPTH;
        r.wr_ok = 1'b1;
      end
    end else if (it.mode == MODE_TAKE) begin
      if (rx_rd[ch] != rx_wr[ch]) begin
        r.rd_data = rx_ring_m[ch][rx_rd[ch]];
        rx_rd[ch] = (rx_rd[ch] + 1) % RX_DEPTH;
        r.rd_valid = 1'b1;
      end
    end
    for (c = 0; c < CHANNELS; c++) begin
      r.tx_lines[c] = tx_level_m[c];
      r.rx_avail[c] = (rx_wr[c] != rx_rd[c]);
    end
    return r;
  endfunction

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // result checking and prediction of accepted items
  always @(posedge clk) begin : scoreboard
    uart_result_t got;
    uart_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_tx_lines, out_read_data, out_read_valid, out_write_accepted,
               out_rx_available};
        if (uart_expect_q.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, got %h", $time, got);
          errors++;
        end else begin
          want = uart_expect_q.pop_front();
          check_field("tx_lines", 8'(want.tx_lines), 8'(got.tx_lines));
          check_field("read_data", want.rd_data, got.rd_data);
          check_field("read_valid", 8'(want.rd_valid), 8'(got.rd_valid));
          check_field("write_accepted", 8'(want.wr_ok), 8'(got.wr_ok));
          check_field("rx_available", 8'(want.rx_avail), 8'(got.rx_avail));
        end
      end
      if (in_valid && in_ready) begin
        want = uart_predict({in_mode, in_channel, in_data_in, in_rx_lines});
        if (row_typed) want = row_expect;
        uart_expect_q.push_back(want);
      end
    end
  end

  // receiver side: stall styles, plus one long hold-off on request
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int rdy_style = RDY_ALWAYS;
  int rdy_left = 0;
  int rdy_cyc = 0;

  always @(posedge clk) begin
    rdy_cyc++;
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      if (rdy_left == 0) begin
        rdy_style = $urandom_range(RDY_ALWAYS, RDY_SPARSE);
        rdy_left = $urandom_range(64, 256);
      end
      rdy_left--;
      case (rdy_style)
        RDY_ALWAYS: out_ready <= 1'b1;
        RDY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        RDY_PERIODIC: out_ready <= ((rdy_cyc % 5) != 0);
        default: out_ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // sender side: bursts of items with random gaps between them
  int burst_left = 0;

  task automatic offer_item(uart_item_t it, logic typed, uart_result_t ex);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_mode <= it.mode;
    in_channel <= it.chan;
    in_data_in <= it.data;
    in_rx_lines <= it.rx;
    row_typed <= typed;
    row_expect <= ex;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (uart_expect_q.size() != 0) @(posedge clk);
  endtask

  function automatic void add_row(logic [1:0] m, logic [1:0] ch, logic [7:0] d,
                                  logic [3:0] rx, logic typed, logic [3:0] tx,
                                  logic [7:0] rd, logic rv, logic wa, logic [3:0] av);
    uart_row_t row;
    row.item = {m, ch, d, rx};
    row.typed = typed;
    row.want = {tx, rd, rv, wa, av};
    stim_rows.push_back(row);
  endfunction

  // serial frame generator state for the receive lines
  int         gen_pos [CHANNELS];
  logic [7:0] gen_byte [CHANNELS];
  logic       gen_stop_ok [CHANNELS];

  initial begin : stimulus
    uart_item_t it;
    int c;
    int i;
    int bitno;
    int counted;
    int phase_len;
    int kind;
    int tick_w;
    int queue_w;
    int take_w;
    int sel;
    int fav;
    logic lvl;
    bit first_phase;

    // model reset
    for (c = 0; c < CHANNELS; c++) begin
      rx_phase_m[c] = 0;
      rx_shift_m[c] = '0;
      rx_wr[c] = 0;
      rx_rd[c] = 0;
      tx_phase_m[c] = 0;
      tx_shift_m[c] = '0;
      tx_wr[c] = 0;
      tx_rd[c] = 0;
      tx_level_m[c] = 1'b1;
      gen_pos[c] = 0;
      gen_byte[c] = 8'($urandom_range(0, 255));
      gen_stop_ok[c] = 1'b1;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty takes, unused mode, idle tick, queue extremes
    add_row(MODE_TAKE, 2'd0, 8'h00, 4'hF, 1'b1, 4'hF, 8'h00, 1'b0, 1'b0, 4'h0);
    add_row(MODE_TAKE, 2'd3, 8'hFF, 4'h0, 1'b1, 4'hF, 8'h00, 1'b0, 1'b0, 4'h0);
    add_row(MODE_UNUSED, 2'd3, 8'hFF, 4'hF, 1'b1, 4'hF, 8'h00, 1'b0, 1'b0, 4'h0);
    add_row(MODE_TICK, 2'd0, 8'h00, 4'hF, 1'b1, 4'hF, 8'h00, 1'b0, 1'b0, 4'h0);
    add_row(MODE_QUEUE, 2'd0, 8'h00, 4'h0, 1'b1, 4'hF, 8'h00, 1'b0, 1'b1, 4'h0);
    add_row(MODE_QUEUE, 2'd1, 8'hFF, 4'hF, 1'b1, 4'hF, 8'h00, 1'b0, 1'b1, 4'h0);
    add_row(MODE_QUEUE, 2'd2, 8'hA5, 4'h5, 1'b1, 4'hF, 8'h00, 1'b0, 1'b1, 4'h0);
    add_row(MODE_QUEUE, 2'd3, 8'h5A, 4'hA, 1'b1, 4'hF, 8'h00, 1'b0, 1'b1, 4'h0);
    // start bits on every receiver while transmitters begin
    add_row(MODE_TICK, 2'd0, 8'h00, 4'h0, 1'b0, '0, '0, 1'b0, 1'b0, '0);
    add_row(MODE_TICK, 2'd0, 8'h00, 4'h0, 1'b0, '0, '0, 1'b0, 1'b0, '0);
    add_row(MODE_TICK, 2'd3, 8'hFF, 4'hF, 1'b0, '0, '0, 1'b0, 1'b0, '0);
    add_row(MODE_TAKE, 2'd1, 8'h00, 4'hF, 1'b0, '0, '0, 1'b0, 1'b0, '0);
    add_row(MODE_QUEUE, 2'd0, 8'h80, 4'hF, 1'b0, '0, '0, 1'b0, 1'b0, '0);
    add_row(MODE_QUEUE, 2'd0, 8'h01, 4'hF, 1'b0, '0, '0, 1'b0, 1'b0, '0);
    add_row(MODE_UNUSED, 2'd0, 8'h00, 4'h0, 1'b0, '0, '0, 1'b0, 1'b0, '0);
    add_row(MODE_TICK, 2'd1, 8'h55, 4'h5, 1'b0, '0, '0, 1'b0, 1'b0, '0);
    add_row(MODE_TICK, 2'd2, 8'hAA, 4'hA, 1'b0, '0, '0, 1'b0, 1'b0, '0);
    for (i = 0; i < stim_rows.size(); i++)
      offer_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
    drain_results();

    // random traffic in phases; the first one lets the receive rings overflow
    counted = 0;
    first_phase = 1'b1;
    while (counted < ITEM_TARGET) begin
      if (first_phase) begin
        kind = PH_QUIET;
        phase_len = 800;
      end else begin
        kind = $urandom_range(PH_QUIET, PH_MIXED);
        phase_len = $urandom_range(80, 300);
      end
      fav = $urandom_range(0, CHANNELS - 1);
      case (kind)
        PH_QUIET: begin tick_w = 97; queue_w = 2; take_w = 0; end
        PH_FLOOD: begin tick_w = 55; queue_w = 40; take_w = 3; end
        PH_DRAIN: begin tick_w = 50; queue_w = 5; take_w = 43; end
        default: begin tick_w = 75; queue_w = 12; take_w = 11; end
      endcase

      for (i = 0; i < phase_len && counted < ITEM_TARGET; i++) begin
        sel = $urandom_range(0, 99);
        it.chan = ($urandom_range(0, 1) == 0) ? CH_W'(fav)
                                               : CH_W'($urandom_range(0, CHANNELS - 1));
        it.data = DATA_W'($urandom_range(0, 255));
        it.rx = LINE_W'($urandom_range(0, 15));
        if (sel < tick_w) begin
          it.mode = MODE_TICK;
          // next tick of each serial frame, with the odd flipped level
          for (c = 0; c < CHANNELS; c++) begin
            if (gen_pos[c] < 0) begin
              lvl = 1'b1;
            end else begin
              bitno = gen_pos[c] / TICKS_PER_BIT;
              if (bitno == 0) lvl = 1'b0;
              else if (bitno <= 8) lvl = gen_byte[c][bitno-1];
              else lvl = gen_stop_ok[c];
            end
            if ($urandom_range(0, 63) == 0) lvl = !lvl;
            it.rx[c] = lvl;
            gen_pos[c]++;
            if (gen_pos[c] == RX_FRAME) begin
              gen_pos[c] = ($urandom_range(0, 1) == 0) ? 0 : -$urandom_range(1, 20);
              gen_byte[c] = 8'($urandom_range(0, 255));
              gen_stop_ok[c] = ($urandom_range(0, 9) != 0);
            end
          end
        end else if (sel < tick_w + queue_w) begin
          it.mode = MODE_QUEUE;
        end else if (sel < tick_w + queue_w + take_w) begin
          it.mode = MODE_TAKE;
        end else begin
          it.mode = MODE_UNUSED;
        end
        offer_item(it, 1'b0, '0);
        if (it.mode != MODE_UNUSED) counted++;
        if (counted == HOLD_AT) hold_req = 1'b1;
      end

      if (first_phase || $urandom_range(0, 2) == 0) drain_results();
      first_phase = 1'b0;
    end

    // wind down
    drain_results();
    repeat (LATENCY + 3) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #(LIMIT_CYCLES * 12);
    $display("tb: failure");
    $finish;
  end

endmodule
